// File: src/dpv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpv_pkg
// Shared constants and the CORDIC arctangent table for the polar velocity unit.
// ----------------------------------------------------------------------------
package dpv_pkg;

    localparam int COORD_BITS_DEF    = 24;
    localparam int FRAC_BITS_DEF     = 8;
    localparam int CORDIC_STAGES_DEF = 16;

    localparam int TT_BITS = 8;
    localparam logic [TT_BITS-1:0] TT_RESET = 8'd3;

    // angle accumulator fraction bits and vector guard bits
    localparam int ANG_FRAC = 24;
    localparam int GUARD    = 24;
    localparam int ACC_BITS = 34;

    // atan(2^-i) in degrees, scaled by 2^24, rounded
    function automatic logic [31:0] atan_deg(input int idx);
        logic [31:0] v;
        case (idx)
            0:  v = 32'd754974720;
            1:  v = 32'd445687602;
            2:  v = 32'd235489088;
            3:  v = 32'd119537938;
            4:  v = 32'd60000934;
            5:  v = 32'd30029717;
            6:  v = 32'd15018523;
            7:  v = 32'd7509720;
            8:  v = 32'd3754917;
            9:  v = 32'd1877466;
            10: v = 32'd938734;
            11: v = 32'd469367;
            12: v = 32'd234684;
            13: v = 32'd117342;
            14: v = 32'd58671;
            15: v = 32'd29335;
            16: v = 32'd14668;
            17: v = 32'd7334;
            18: v = 32'd3667;
            19: v = 32'd1833;
            20: v = 32'd917;
            21: v = 32'd458;
            22: v = 32'd229;
            23: v = 32'd115;
            24: v = 32'd57;
            25: v = 32'd29;
            26: v = 32'd14;
            27: v = 32'd7;
            28: v = 32'd4;
            29: v = 32'd2;
            30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// File: src/dpv_delay.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpv_delay
// Enabled shift line used to align side data with the compute chains.
// ----------------------------------------------------------------------------
module dpv_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic [WIDTH-1:0] d,
    output logic [WIDTH-1:0] q
);

    generate
        if (DEPTH == 0)
        begin : g_pass
            assign q = d;
        end
        else
        begin : g_line
            logic [WIDTH-1:0] tap_reg [DEPTH];

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    for (int i = 0; i < DEPTH; i++)
                    begin
                        tap_reg[i] <= '0;
                    end
                end
                else if (en)
                begin
                    tap_reg[0] <= d;
                    for (int i = 1; i < DEPTH; i++)
                    begin
                        tap_reg[i] <= tap_reg[i-1];
                    end
                end
            end

            assign q = tap_reg[DEPTH-1];
        end
    endgenerate

endmodule

// File: src/dpv_sqrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpv_sqrt_cell
// One restoring square root step: retires one root bit per cell.
// ----------------------------------------------------------------------------
module dpv_sqrt_cell #(
    parameter int RB = 25
) (
    input  logic              clk,
    input  logic              en,
    input  logic [2*RB-1:0]   rad_in,
    input  logic [RB+1:0]     rem_in,
    input  logic [RB-1:0]     root_in,
    output logic [2*RB-1:0]   rad_out,
    output logic [RB+1:0]     rem_out,
    output logic [RB-1:0]     root_out
);

    logic [2*RB-1:0] rad_reg;
    logic [RB+1:0]   rem_reg;
    logic [RB-1:0]   root_reg;
    logic [RB+1:0]   part;
    logic [RB+1:0]   trial;
    logic            fits;

    always_comb
    begin
        part  = {rem_in[RB-1:0], rad_in[2*RB-1 -: 2]};
        trial = {root_in, 2'b01};
        fits  = (part >= trial);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg  <= {rad_in[2*RB-3:0], 2'b00};
            rem_reg  <= fits ? (part - trial) : part;
            root_reg <= {root_in[RB-2:0], fits};
        end
    end

    assign rad_out  = rad_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;

endmodule

// File: src/dpv_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpv_div_cell
// One restoring division step by the travel time: one quotient bit per cell.
// ----------------------------------------------------------------------------
module dpv_div_cell
    import dpv_pkg::*;
#(
    parameter int DW = 26
) (
    input  logic               clk,
    input  logic               en,
    input  logic [TT_BITS-1:0] divisor,
    input  logic [DW-1:0]      num_in,
    input  logic [TT_BITS-1:0] rem_in,
    input  logic [DW-1:0]      q_in,
    output logic [DW-1:0]      num_out,
    output logic [TT_BITS-1:0] rem_out,
    output logic [DW-1:0]      q_out
);

    logic [DW-1:0]      num_reg;
    logic [TT_BITS-1:0] rem_reg;
    logic [DW-1:0]      q_reg;
    logic [TT_BITS:0]   part;
    logic [TT_BITS:0]   diff;
    logic               fits;

    always_comb
    begin
        part = {rem_in, num_in[DW-1]};
        diff = part - {1'b0, divisor};
        fits = (part >= {1'b0, divisor});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg <= {num_in[DW-2:0], 1'b0};
            rem_reg <= fits ? diff[TT_BITS-1:0] : part[TT_BITS-1:0];
            q_reg   <= {q_in[DW-2:0], fits};
        end
    end

    assign num_out = num_reg;
    assign rem_out = rem_reg;
    assign q_out   = q_reg;

endmodule

// File: src/dpv_cordic_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpv_cordic_cell
// One vectoring micro-rotation: drives y toward zero, accumulates the angle.
// ----------------------------------------------------------------------------
module dpv_cordic_cell
    import dpv_pkg::*;
#(
    parameter int XW    = 51,
    parameter int STAGE = 0
) (
    input  logic                       clk,
    input  logic                       en,
    input  logic signed [XW-1:0]       x_in,
    input  logic signed [XW-1:0]       y_in,
    input  logic signed [ACC_BITS-1:0] acc_in,
    output logic signed [XW-1:0]       x_out,
    output logic signed [XW-1:0]       y_out,
    output logic signed [ACC_BITS-1:0] acc_out
);

    localparam logic signed [ACC_BITS-1:0] ANG = ACC_BITS'(atan_deg(STAGE));

    logic signed [XW-1:0]       x_reg;
    logic signed [XW-1:0]       y_reg;
    logic signed [ACC_BITS-1:0] acc_reg;
    logic signed [XW-1:0]       xs;
    logic signed [XW-1:0]       ys;
    logic                       up;

    always_comb
    begin
        xs = y_in >>> STAGE;
        ys = x_in >>> STAGE;
        up = !y_in[XW-1] && (y_in != '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (up)
            begin
                x_reg   <= x_in + xs;
                y_reg   <= y_in - ys;
                acc_reg <= acc_in + ANG;
            end
            else
            begin
                x_reg   <= x_in - xs;
                y_reg   <= y_in + ys;
                acc_reg <= acc_in - ANG;
            end
        end
    end

    assign x_out   = x_reg;
    assign y_out   = y_reg;
    assign acc_out = acc_reg;

endmodule

// File: src/displacement_to_polar_velocity_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// displacement_to_polar_velocity_unit
// Displacement of two points to distance, speed, heading and velocity.
// ----------------------------------------------------------------------------
// The square root chain plus the divider chain set the delay from accepted request
//   to out_valid, while they are longer than the CORDIC chain (as at defaults).
// Throughput: one request per cycle; the whole pipeline holds while a result
//   waits on out_stall.
// Reset clears all valid state and sets travel_time to 3; no clearing pass.
module displacement_to_polar_velocity_unit
    import dpv_pkg::*;
#(
    parameter int COORD_BITS    = COORD_BITS_DEF,
    parameter int FRAC_BITS     = FRAC_BITS_DEF,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic signed [COORD_BITS-1:0]   start_x,
    input  logic signed [COORD_BITS-1:0]   start_y,
    input  logic signed [COORD_BITS-1:0]   end_x,
    input  logic signed [COORD_BITS-1:0]   end_y,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [COORD_BITS:0]            distance,
    output logic [COORD_BITS:0]            speed,
    output logic signed [FRAC_BITS+8:0]    heading_deg,
    output logic signed [COORD_BITS:0]     velocity_x,
    output logic signed [COORD_BITS:0]     velocity_y,
    output logic                           zero_displacement,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [TT_BITS-1:0]             cfg_data
);

    localparam int C   = COORD_BITS;
    localparam int RB  = COORD_BITS + 1;
    localparam int DW  = RB + 1;
    localparam int HW  = FRAC_BITS + 9;
    localparam int N   = CORDIC_STAGES;
    localparam int XW  = COORD_BITS + GUARD + 3;
    localparam int AW  = ACC_BITS;
    localparam int SH  = ANG_FRAC - FRAC_BITS;
    localparam int L_D = 3 + RB;
    localparam int L_S = L_D + DW;
    localparam int L_C = 2 + N;
    localparam int TOT = (L_S > L_C) ? L_S : L_C;

    localparam logic signed [AW-1:0] ACC_180 = AW'(64'sd180 <<< ANG_FRAC);
    localparam logic signed [AW-1:0] RND     = AW'(64'sd1 <<< (SH - 1));
    localparam logic signed [AW-1:0] LIM     = AW'(64'sd180 <<< FRAC_BITS);

    logic adv;

    // configuration
    logic [TT_BITS-1:0] travel_time_reg;
    logic [TT_BITS-1:0] tdiv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            travel_time_reg <= TT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            travel_time_reg <= cfg_data;
        end
    end

    assign cfg_ready = 1'b1;
    assign tdiv      = (travel_time_reg == '0) ? TT_BITS'(1) : travel_time_reg;

    // level 0: displacement
    logic                 v0_reg;
    logic                 zero0_reg;
    logic signed [RB-1:0] dx_reg;
    logic signed [RB-1:0] dy_reg;
    logic signed [RB-1:0] dx_next;
    logic signed [RB-1:0] dy_next;

    assign adv      = !out_valid || !out_stall;
    assign in_stall = !adv;
    assign dx_next  = RB'(end_x) - RB'(start_x);
    assign dy_next  = RB'(end_y) - RB'(start_y);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (adv)
        begin
            v0_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dx_reg    <= dx_next;
            dy_reg    <= dy_next;
            zero0_reg <= (dx_next == '0) && (dy_next == '0);
        end
    end

    // magnitude: squares, sum, root chain, rounding
    logic [RB-1:0]   ax_full;
    logic [RB-1:0]   ay_full;
    logic [2*C-1:0]  sqx_reg;
    logic [2*C-1:0]  sqy_reg;
    logic [2*RB-1:0] sum_reg;
    logic [RB-1:0]   dist_reg;

    assign ax_full = dx_reg[RB-1] ? RB'(-dx_reg) : RB'(dx_reg);
    assign ay_full = dy_reg[RB-1] ? RB'(-dy_reg) : RB'(dy_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sqx_reg <= ax_full[C-1:0] * ax_full[C-1:0];
            sqy_reg <= ay_full[C-1:0] * ay_full[C-1:0];
            sum_reg <= (2*RB)'(sqx_reg) + (2*RB)'(sqy_reg);
        end
    end

    logic [2*RB-1:0] sq_rad  [RB+1];
    logic [RB+1:0]   sq_rem  [RB+1];
    logic [RB-1:0]   sq_root [RB+1];

    assign sq_rad[0]  = sum_reg;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;

    generate
        for (genvar k = 0; k < RB; k++)
        begin : g_sqrt
            dpv_sqrt_cell #(
                .RB (RB)
            ) u_cell (
                .clk      (clk),
                .en       (adv),
                .rad_in   (sq_rad[k]),
                .rem_in   (sq_rem[k]),
                .root_in  (sq_root[k]),
                .rad_out  (sq_rad[k+1]),
                .rem_out  (sq_rem[k+1]),
                .root_out (sq_root[k+1])
            );
        end
    endgenerate

    // round half up: bump when remainder exceeds the root
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dist_reg <= sq_root[RB] + RB'(sq_rem[RB] > {2'b00, sq_root[RB]});
        end
    end

    // displacement aligned with the rounded distance
    logic signed [RB-1:0] dxd;
    logic signed [RB-1:0] dyd;

    dpv_delay #(
        .WIDTH (2*RB),
        .DEPTH (L_D)
    ) u_dd (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (adv),
        .d     ({dx_reg, dy_reg}),
        .q     ({dxd, dyd})
    );

    // three divider lanes: speed, x, y
    logic [RB-1:0] axd;
    logic [RB-1:0] ayd;
    logic [DW-1:0] dv_num [3][DW+1];
    logic [TT_BITS-1:0] dv_rem [3][DW+1];
    logic [DW-1:0] dv_q   [3][DW+1];

    assign axd = dxd[RB-1] ? RB'(-dxd) : RB'(dxd);
    assign ayd = dyd[RB-1] ? RB'(-dyd) : RB'(dyd);

    assign dv_num[0][0] = DW'(dist_reg) + DW'(tdiv >> 1);
    assign dv_num[1][0] = DW'(axd) + DW'(tdiv >> 1);
    assign dv_num[2][0] = DW'(ayd) + DW'(tdiv >> 1);

    generate
        for (genvar ln = 0; ln < 3; ln++)
        begin : g_lane
            assign dv_rem[ln][0] = '0;
            assign dv_q[ln][0]   = '0;
            for (genvar k = 0; k < DW; k++)
            begin : g_div
                dpv_div_cell #(
                    .DW (DW)
                ) u_cell (
                    .clk     (clk),
                    .en      (adv),
                    .divisor (tdiv),
                    .num_in  (dv_num[ln][k]),
                    .rem_in  (dv_rem[ln][k]),
                    .q_in    (dv_q[ln][k]),
                    .num_out (dv_num[ln][k+1]),
                    .rem_out (dv_rem[ln][k+1]),
                    .q_out   (dv_q[ln][k+1])
                );
            end
        end
    endgenerate

    logic [1:0]           neg_s;
    logic [RB-1:0]        qx;
    logic [RB-1:0]        qy;
    logic [RB-1:0]        spd_s;
    logic [RB-1:0]        vx_s;
    logic [RB-1:0]        vy_s;
    logic [RB-1:0]        spd_t;
    logic [RB-1:0]        vx_t;
    logic [RB-1:0]        vy_t;

    dpv_delay #(
        .WIDTH (2),
        .DEPTH (DW)
    ) u_sgn (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (adv),
        .d     ({dxd[RB-1], dyd[RB-1]}),
        .q     (neg_s)
    );

    assign spd_s = dv_q[0][DW][RB-1:0];
    assign qx    = dv_q[1][DW][RB-1:0];
    assign qy    = dv_q[2][DW][RB-1:0];
    assign vx_s  = neg_s[1] ? -qx : qx;
    assign vy_s  = neg_s[0] ? -qy : qy;

    dpv_delay #(
        .WIDTH (3*RB),
        .DEPTH (TOT - L_S)
    ) u_vd (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (adv),
        .d     ({spd_s, vx_s, vy_s}),
        .q     ({spd_t, vx_t, vy_t})
    );

    // heading: half-plane fold, CORDIC chain, rounding and clamp
    logic signed [XW-1:0] cd_x   [N+1];
    logic signed [XW-1:0] cd_y   [N+1];
    logic signed [AW-1:0] cd_acc [N+1];
    logic signed [XW-1:0] x0_reg;
    logic signed [XW-1:0] y0_reg;
    logic signed [AW-1:0] acc0_reg;
    logic signed [XW-1:0] dxw;
    logic signed [XW-1:0] dyw;

    assign dxw = XW'(dx_reg);
    assign dyw = XW'(dy_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (dx_reg[RB-1])
            begin
                x0_reg   <= (-dxw) <<< GUARD;
                y0_reg   <= (-dyw) <<< GUARD;
                acc0_reg <= dy_reg[RB-1] ? -ACC_180 : ACC_180;
            end
            else
            begin
                x0_reg   <= dxw <<< GUARD;
                y0_reg   <= dyw <<< GUARD;
                acc0_reg <= '0;
            end
        end
    end

    assign cd_x[0]   = x0_reg;
    assign cd_y[0]   = y0_reg;
    assign cd_acc[0] = acc0_reg;

    generate
        for (genvar i = 0; i < N; i++)
        begin : g_cordic
            dpv_cordic_cell #(
                .XW    (XW),
                .STAGE (i)
            ) u_cell (
                .clk     (clk),
                .en      (adv),
                .x_in    (cd_x[i]),
                .y_in    (cd_y[i]),
                .acc_in  (cd_acc[i]),
                .x_out   (cd_x[i+1]),
                .y_out   (cd_y[i+1]),
                .acc_out (cd_acc[i+1])
            );
        end
    endgenerate

    logic signed [AW-1:0] acc_rnd;
    logic signed [AW-1:0] acc_clamp;
    logic [HW-1:0]        head_reg;
    logic [HW-1:0]        head_t;

    always_comb
    begin
        acc_rnd = (cd_acc[N] + RND) >>> SH;
        if (acc_rnd > LIM)
        begin
            acc_clamp = LIM;
        end
        else if (acc_rnd < -LIM)
        begin
            acc_clamp = -LIM;
        end
        else
        begin
            acc_clamp = acc_rnd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            head_reg <= acc_clamp[HW-1:0];
        end
    end

    dpv_delay #(
        .WIDTH (HW),
        .DEPTH (TOT - L_C)
    ) u_hd (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (adv),
        .d     (head_reg),
        .q     (head_t)
    );

    // request tracking
    logic v_t;
    logic zero_t;

    dpv_delay #(
        .WIDTH (2),
        .DEPTH (TOT)
    ) u_vz (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (adv),
        .d     ({v0_reg, zero0_reg}),
        .q     ({v_t, zero_t})
    );

    // output register
    logic          out_valid_reg;
    logic          zero_reg;
    logic [RB-1:0] dist_o_reg;
    logic [RB-1:0] spd_o_reg;
    logic [HW-1:0] head_o_reg;
    logic [RB-1:0] vx_o_reg;
    logic [RB-1:0] vy_o_reg;
    logic [RB-1:0] dist_t;

    dpv_delay #(
        .WIDTH (RB),
        .DEPTH (TOT - L_D)
    ) u_dist (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (adv),
        .d     (dist_reg),
        .q     (dist_t)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= v_t;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            zero_reg   <= zero_t;
            dist_o_reg <= dist_t;
            spd_o_reg  <= spd_t;
            head_o_reg <= zero_t ? '0 : head_t;
            vx_o_reg   <= vx_t;
            vy_o_reg   <= vy_t;
        end
    end

    assign out_valid         = out_valid_reg;
    assign zero_displacement = zero_reg;
    assign distance          = dist_o_reg;
    assign speed             = spd_o_reg;
    assign heading_deg       = head_o_reg;
    assign velocity_x        = vx_o_reg;
    assign velocity_y        = vy_o_reg;

`ifndef SYNTHESIS
    a_zero_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_displacement |->
            heading_deg == '0 && distance == '0 && velocity_x == '0 && velocity_y == '0)
        else $error("zero displacement result not cleared");

    a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (AW'(heading_deg) <= LIM) && (AW'(heading_deg) >= -LIM))
        else $error("heading out of range");

    a_speed_le_dist: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> speed <= distance)
        else $error("speed exceeds distance");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> $stable(dist_reg) && $stable(head_reg))
        else $error("pipeline moved while stalled");
`endif

endmodule
